// File: rtl/core/cmfta_pkg.sv
// shared field widths, face codes and register indexes for cube map texel addressing
package cmfta_pkg;

  // result field widths
  localparam int FACE_W   = 3;
  localparam int TEXEL_W  = 10;
  localparam int INDEX_W  = 20;
  localparam int M_TDATA_W = 48;

  // configuration port
  localparam int CFG_W      = 11;
  localparam int CFG_IDX_W  = 1;
  localparam int SIZE_RESET = 128;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FACE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FACE_HEIGHT = 1'b1;

  // face codes
  localparam logic [FACE_W-1:0] FACE_POS_X = 3'd0;
  localparam logic [FACE_W-1:0] FACE_NEG_X = 3'd1;
  localparam logic [FACE_W-1:0] FACE_POS_Y = 3'd2;
  localparam logic [FACE_W-1:0] FACE_NEG_Y = 3'd3;
  localparam logic [FACE_W-1:0] FACE_POS_Z = 3'd4;
  localparam logic [FACE_W-1:0] FACE_NEG_Z = 3'd5;

endpackage

// File: rtl/core/cube_map_face_texel_address.sv
// cube map face selection and nearest-texel addressing pipeline
//
//  channel   dir  handshake                 payload
//  s_axis    in   tvalid/tready             tdata: dir_x, dir_y, dir_z
//  m_axis    out  tvalid/tready             tdata: face, texel_u, texel_v, texel_index
//                                           tuser: zero_vector
//  cfg       in   we (no back-pressure)     index, data
//
// one word per cycle while the output is not stalled; a word passes through stages 1 to 3, the
// divider stages, the clamp stage and the output stage; the divider resolves SB = $clog2(MAX_FACE_SIZE+1)
// quotient bits, one per pipeline stage, for u and v side by side.
// reset clears all valid bits and loads both face sizes with 128, or with MAX_FACE_SIZE if that is smaller.
// the whole pipeline advances when the output register is empty or taken; a stall
// freezes every stage, so nothing is dropped or repeated.
module cube_map_face_texel_address #(
  parameter int MAX_FACE_SIZE  = 1024,
  parameter int COMPONENT_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration write port
  input  logic                                 cfg_we_i,
  input  logic [cmfta_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [cmfta_pkg::CFG_W-1:0]          cfg_data_i,
  // input words
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // dir_x, dir_y, dir_z, zero padding
  input  logic [((3*COMPONENT_BITS+7)/8)*8-1:0] s_axis_tdata_i,
  // result words
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  // face, texel_u, texel_v, texel_index, zero padding
  output logic [cmfta_pkg::M_TDATA_W-1:0]      m_axis_tdata_o,
  // zero_vector
  output logic                                 m_axis_tuser_o
);

  localparam int CB = COMPONENT_BITS;
  localparam int SB = $clog2(MAX_FACE_SIZE + 1);
  localparam int AW = CB + 1;
  localparam int NB = AW + SB;
  localparam int QB = SB;
  localparam int FW = cmfta_pkg::FACE_W;
  localparam int TW = cmfta_pkg::TEXEL_W;
  localparam int XW = cmfta_pkg::INDEX_W;
  localparam int OW = cmfta_pkg::M_TDATA_W;
  localparam int IW = 2 * SB + 1;
  localparam int RESET_SIZE = (cmfta_pkg::SIZE_RESET > MAX_FACE_SIZE) ?
                              MAX_FACE_SIZE : cmfta_pkg::SIZE_RESET;

  typedef struct packed {
    logic [AW-1:0] rem_u;
    logic [AW-1:0] rem_v;
    logic [QB-1:0] low_u;
    logic [QB-1:0] low_v;
    logic [QB-1:0] quo_u;
    logic [QB-1:0] quo_v;
    logic [AW-1:0] dvs;
    logic [FW-1:0] face;
    logic          zero;
  } div_t;

  logic          en;

  logic [SB-1:0] size_w_q, size_h_q;
  logic [SB-1:0] size_d;

  logic signed [CB-1:0] cx, cy, cz;
  logic [CB-1:0] ax, ay, az;
  logic [AW-1:0] px, py, pz, nx, ny, nz;
  logic [FW-1:0] face_d;
  logic [CB-1:0] mag_d;
  logic [AW-1:0] su_d, sv_d;

  logic          v1_q, v2_q, v3_q, v4_q;
  logic [FW-1:0] face1_q, face2_q;
  logic [CB-1:0] mag1_q;
  logic [AW-1:0] su1_q, sv1_q;
  logic          zero1_q, zero2_q;
  logic [AW-1:0] au2_q, av2_q, dvs2_q;
  logic [NB-1:0] num_u, num_v;

  div_t          div_q [QB+1];
  logic          dv_q  [QB+1];

  logic [QB-1:0] tu4_q, tv4_q;
  logic [FW-1:0] face4_q;
  logic          zero4_q;
  logic [QB-1:0] tu_d, tv_d;

  logic [IW-1:0] index_d;
  logic          out_valid_q;
  logic [FW-1:0] out_face_q;
  logic [QB-1:0] out_u_q, out_v_q;
  logic [XW-1:0] out_index_q;
  logic          out_zero_q;

  // global advance: output register empty or being taken
  assign en = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = en;

  // effective face size: zero reads as one, large values saturate
  always_comb begin
    if (cfg_data_i == '0) begin
      size_d = SB'(1);
    end else if (int'(cfg_data_i) > MAX_FACE_SIZE) begin
      size_d = SB'(MAX_FACE_SIZE);
    end else begin
      size_d = SB'(cfg_data_i);
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_w_q <= SB'(RESET_SIZE);
      size_h_q <= SB'(RESET_SIZE);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        cmfta_pkg::REG_FACE_WIDTH:  size_w_q <= size_d;
        cmfta_pkg::REG_FACE_HEIGHT: size_h_q <= size_d;
        default: ;
      endcase
    end
  end

  // stage 1: magnitudes, major axis and projected coordinates
  always_comb begin
    cx = $signed(s_axis_tdata_i[CB-1:0]);
    cy = $signed(s_axis_tdata_i[2*CB-1:CB]);
    cz = $signed(s_axis_tdata_i[3*CB-1:2*CB]);
    ax = cx[CB-1] ? (~cx + 1'b1) : cx;
    ay = cy[CB-1] ? (~cy + 1'b1) : cy;
    az = cz[CB-1] ? (~cz + 1'b1) : cz;
    px = {cx[CB-1], cx};
    py = {cy[CB-1], cy};
    pz = {cz[CB-1], cz};
    nx = ~px + 1'b1;
    ny = ~py + 1'b1;
    nz = ~pz + 1'b1;
    // ties go to the lower axis
    if (ax >= ay && ax >= az) begin
      mag_d  = ax;
      face_d = cx[CB-1] ? cmfta_pkg::FACE_NEG_X : cmfta_pkg::FACE_POS_X;
    end else if (ay >= az) begin
      mag_d  = ay;
      face_d = cy[CB-1] ? cmfta_pkg::FACE_NEG_Y : cmfta_pkg::FACE_POS_Y;
    end else begin
      mag_d  = az;
      face_d = cz[CB-1] ? cmfta_pkg::FACE_NEG_Z : cmfta_pkg::FACE_POS_Z;
    end
    // per-face orientation
    unique case (face_d)
      cmfta_pkg::FACE_POS_X: begin su_d = nz; sv_d = ny; end
      cmfta_pkg::FACE_NEG_X: begin su_d = pz; sv_d = ny; end
      cmfta_pkg::FACE_POS_Y: begin su_d = px; sv_d = pz; end
      cmfta_pkg::FACE_NEG_Y: begin su_d = px; sv_d = nz; end
      cmfta_pkg::FACE_POS_Z: begin su_d = px; sv_d = ny; end
      default:               begin su_d = nx; sv_d = ny; end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      face1_q <= face_d;
      mag1_q  <= mag_d;
      su1_q   <= su_d;
      sv1_q   <= sv_d;
      zero1_q <= (mag_d == '0);
    end
  end

  // stage 2: shift coordinates to [0, 2m] and form the divisor
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      au2_q   <= su1_q + AW'(mag1_q);
      av2_q   <= sv1_q + AW'(mag1_q);
      dvs2_q  <= {mag1_q, 1'b0};
      face2_q <= face1_q;
      zero2_q <= zero1_q;
    end
  end

  // stage 3: scale by face size, split dividend into start remainder and low bits
  assign num_u = NB'(au2_q) * NB'(size_w_q);
  assign num_v = NB'(av2_q) * NB'(size_h_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= 1'b0;
    end else if (en) begin
      dv_q[0] <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      div_q[0].rem_u <= num_u[NB-1:QB];
      div_q[0].rem_v <= num_v[NB-1:QB];
      div_q[0].low_u <= num_u[QB-1:0];
      div_q[0].low_v <= num_v[QB-1:0];
      div_q[0].quo_u <= '0;
      div_q[0].quo_v <= '0;
      div_q[0].dvs   <= dvs2_q;
      div_q[0].face  <= face2_q;
      div_q[0].zero  <= zero2_q;
    end
  end

  // divider stages: one restoring step per stage for u and v
  for (genvar k = 0; k < QB; k++) begin : g_div
    logic [AW:0] trial_u, trial_v;
    logic        hit_u, hit_v;
    div_t        nxt;

    always_comb begin
      trial_u = {div_q[k].rem_u, div_q[k].low_u[QB-1]};
      trial_v = {div_q[k].rem_v, div_q[k].low_v[QB-1]};
      hit_u   = trial_u >= {1'b0, div_q[k].dvs};
      hit_v   = trial_v >= {1'b0, div_q[k].dvs};
      nxt       = div_q[k];
      nxt.rem_u = hit_u ? AW'(trial_u - {1'b0, div_q[k].dvs}) : trial_u[AW-1:0];
      nxt.rem_v = hit_v ? AW'(trial_v - {1'b0, div_q[k].dvs}) : trial_v[AW-1:0];
      nxt.low_u = div_q[k].low_u << 1;
      nxt.low_v = div_q[k].low_v << 1;
      nxt.quo_u = (div_q[k].quo_u << 1) | QB'(hit_u);
      nxt.quo_v = (div_q[k].quo_v << 1) | QB'(hit_v);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k+1] <= 1'b0;
      end else if (en) begin
        dv_q[k+1] <= dv_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        div_q[k+1] <= nxt;
      end
    end
  end

  // clamp stage: far face edge lands on size - 1
  always_comb begin
    tu_d = (div_q[QB].quo_u > size_w_q - 1'b1) ? size_w_q - 1'b1 : div_q[QB].quo_u;
    tv_d = (div_q[QB].quo_v > size_h_q - 1'b1) ? size_h_q - 1'b1 : div_q[QB].quo_v;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en) begin
      v4_q <= dv_q[QB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tu4_q   <= tu_d;
      tv4_q   <= tv_d;
      face4_q <= div_q[QB].face;
      zero4_q <= div_q[QB].zero;
    end
  end

  // output stage: linear index, zero vector override
  assign index_d = IW'(tv4_q) * IW'(size_w_q) + IW'(tu4_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_zero_q  <= zero4_q;
      out_face_q  <= zero4_q ? '0 : face4_q;
      out_u_q     <= zero4_q ? '0 : tu4_q;
      out_v_q     <= zero4_q ? '0 : tv4_q;
      out_index_q <= zero4_q ? '0 : XW'(index_d);
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_zero_q;
  assign m_axis_tdata_o  = {(OW - FW - 2 * TW - XW)'(0), out_index_q,
                            TW'(out_v_q), TW'(out_u_q), out_face_q};

`ifndef SYNTHESIS
  // zero vector word carries face 0, texel_u 0 and texel index 0
  a_zero_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_zero_q |-> out_face_q == '0 && out_index_q == '0 && out_u_q == '0)
    else $error("zero vector word with nonzero address");

  // face code stays within the six faces
  a_face_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_face_q <= cmfta_pkg::FACE_NEG_Z)
    else $error("face code out of range");

  // clamp keeps texel inside the face
  a_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_u_q < size_w_q && out_v_q < size_h_q)
    else $error("texel outside face");

  // a stalled result word is held
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready_i |=> out_valid_q && $stable(m_axis_tdata_o)
      && $stable(m_axis_tuser_o))
    else $error("stalled result word changed");
`endif

endmodule
